FILE: hdl/fixed_block_pool_allocator_defines.svh
// assertion macros for the checker file
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FBPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/fbpa_pkg.sv
// types, constants and codes of the fixed block pool allocator
package fbpa_pkg;

   localparam int MAX_BLOCKS     = 64;
   localparam int POOL_BYTES_MAX = 1048576;

   localparam int BB_W      = 17;
   localparam int POOL_W    = 21;
   localparam int OFF_W     = 20;
   localparam int STAT_W    = 2;
   localparam int CSR_W     = 21;
   localparam int CSR_IDX_W = 1;

   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int PMAX_W = $clog2(POOL_BYTES_MAX + 1);
   localparam int DVD_W  = (PMAX_W > OFF_W) ? PMAX_W : OFF_W;
   localparam int SHD_W  = ((BB_W + CNT_W) > DVD_W) ? (BB_W + CNT_W) : DVD_W;
   localparam int STEP_W = $clog2(CNT_W + 1);
   localparam int PROD_W = IDX_W + BB_W;

   localparam logic [BB_W-1:0]   BB_RST   = BB_W'(64);
   localparam logic [POOL_W-1:0] POOL_RST = POOL_W'(4096);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BYTES  = CSR_IDX_W'(1);

   typedef enum logic [STAT_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_EMPTY        = 2'd1,
      STAT_INVALID      = 2'd2,
      STAT_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_RBLD,
      S_FDIV,
      S_FCHK,
      S_SCAN
   } state_type;

endpackage

FILE: hdl/fixed_block_pool_allocator.sv
// fixed block pool allocator: alloc scans the used flags (one used flag per cycle,
// highest index first), free runs a restoring divider (one quotient bit per cycle,
// cut short when the quotient cannot fit); the next start is taken in the result cycle
// reset and every register write rebuild the pool: block count by the same divider,
// with busy high, then all blocks free
// the receiver cannot stall; results are never held back; rsp_valid pulses one cycle
module fixed_block_pool_allocator
   import fbpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [OFF_W-1:0]     req_offset_in,
   output logic                 rsp_valid,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [OFF_W-1:0]     rsp_offset_out,
   output logic [CNT_W-1:0]     rsp_free_left,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   state_type               state_ff, state_in;
   logic [BB_W-1:0]         bb_ff, bb_in;
   logic [POOL_W-1:0]       pool_ff, pool_in;
   logic [MAX_BLOCKS-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic [CNT_W-1:0]        free_ff, free_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [DVD_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        quo_ff, quo_in;
   logic                    ovf_ff, ovf_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]        rsp_offset_ff, rsp_offset_in;
   logic [CNT_W-1:0]        rsp_free_ff, rsp_free_in;

   // shared divider datapath
   logic [SHD_W-1:0]  dsh;
   logic              ge;
   logic              div_done;
   logic [DVD_W-1:0]  div_rem_nx;
   logic [CNT_W-1:0]  div_quo_nx;
   logic              div_ovf_nx;
   logic [DVD_W-1:0]  pool_clamped;
   logic [PROD_W-1:0] prod;
   logic              free_bad;

   assign dsh  = SHD_W'(bb_ff) << step_ff;
   assign ge   = SHD_W'(rem_ff) >= dsh;
   assign prod = PROD_W'(scan_idx_ff) * PROD_W'(bb_ff);

   assign pool_clamped = (32'(pool_ff) > 32'(POOL_BYTES_MAX)) ?
                         DVD_W'(POOL_BYTES_MAX) : DVD_W'(pool_ff);

   always_comb begin
      div_rem_nx = rem_ff;
      div_quo_nx = quo_ff;
      div_ovf_nx = ovf_ff;
      div_done   = 1'b0;
      if (step_ff == STEP_W'(CNT_W)) begin
         // quotient would not fit if ge: flag overflow and stop
         div_ovf_nx = ge;
         div_done   = ge;
      end else begin
         if (ge) begin
            div_rem_nx = rem_ff - DVD_W'(dsh);
            div_quo_nx = quo_ff | (CNT_W'(1) << step_ff);
         end
         div_done = (step_ff == '0);
      end
   end

   assign free_bad = (bb_ff == '0) || ovf_ff || (rem_ff != '0) || (quo_ff >= total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         bb_ff        <= BB_RST;
         pool_ff      <= POOL_RST;
         used_ff      <= '0;
         total_ff     <= '0;
         free_ff      <= '0;
         step_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bb_ff        <= bb_in;
         pool_ff      <= pool_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         step_ff      <= step_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_comb begin
      state_in      = state_ff;
      bb_in         = bb_ff;
      pool_in       = pool_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      scan_idx_in   = scan_idx_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      ovf_in        = ovf_ff;
      step_in       = step_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_free_in   = rsp_free_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_action == ACT_FREE) begin
                  rem_in   = DVD_W'(req_offset_in);
                  quo_in   = '0;
                  ovf_in   = 1'b0;
                  step_in  = STEP_W'(CNT_W);
                  state_in = S_FDIV;
               end else begin
                  scan_idx_in = IDX_W'(total_ff - CNT_W'(1));
                  state_in    = S_SCAN;
               end
            end
         end
         S_INIT: begin
            rem_in  = pool_clamped;
            quo_in  = '0;
            ovf_in  = 1'b0;
            step_in = STEP_W'(CNT_W);
            used_in = '0;
            if (bb_ff == '0) begin
               total_in = '0;
               free_in  = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_RBLD;
            end
         end
         S_RBLD, S_FDIV: begin
            rem_in  = div_rem_nx;
            quo_in  = div_quo_nx;
            ovf_in  = div_ovf_nx;
            step_in = step_ff - STEP_W'(1);
            if (div_done) begin
               if (state_ff == S_RBLD) begin
                  if (div_ovf_nx || (div_quo_nx > CNT_W'(MAX_BLOCKS))) begin
                     total_in = CNT_W'(MAX_BLOCKS);
                  end else begin
                     total_in = div_quo_nx;
                  end
                  free_in  = total_in;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FCHK;
               end
            end
         end
         S_FCHK: begin
            rsp_valid_in  = 1'b1;
            rsp_offset_in = '0;
            if (free_bad) begin
               rsp_status_in = STAT_INVALID;
            end else if (!used_ff[quo_ff[IDX_W-1:0]]) begin
               rsp_status_in = STAT_ALREADY_FREE;
            end else begin
               rsp_status_in                = STAT_OK;
               used_in[quo_ff[IDX_W-1:0]]   = 1'b0;
               if (free_ff < total_ff) begin
                  free_in = free_ff + CNT_W'(1);
               end
            end
            rsp_free_in = free_in;
            state_in    = S_IDLE;
         end
         S_SCAN: begin
            if (total_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_EMPTY;
               rsp_offset_in = '0;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end else if (!used_ff[scan_idx_ff]) begin
               used_in[scan_idx_ff] = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - CNT_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_offset_in = OFF_W'(prod);
               rsp_free_in   = free_in;
               state_in      = S_IDLE;
            end else if (scan_idx_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_EMPTY;
               rsp_offset_in = '0;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write re-initializes the pool
      if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_BYTES: begin
               bb_in    = csr_wdata[BB_W-1:0];
               state_in = S_INIT;
            end
            CSR_POOL_BYTES: begin
               pool_in  = csr_wdata[POOL_W-1:0];
               state_in = S_INIT;
            end
            default: begin
            end
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_offset_out = rsp_offset_ff;
   assign rsp_free_left  = rsp_free_ff;

endmodule

FILE: hdl/fbpa_checker.sv
// port-level checker for the fixed block pool allocator, bound to the top level
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_checker
   import fbpa_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [STAT_W-1:0] rsp_status,
   input logic [OFF_W-1:0]  rsp_offset_out,
   input logic [CNT_W-1:0]  rsp_free_left
);

   // a start while idle makes the block busy in the next cycle
   `FBPA_ASSERT_NXT(a_busy_after_start, clock, reset, start && !busy, busy, "not busy after start")
   // result strobe is a single-cycle pulse
   `FBPA_ASSERT_NXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held")
   // a failed item carries no offset
   `FBPA_ASSERT_IMP(a_zero_offset, clock, reset, rsp_valid && (rsp_status != STAT_OK), rsp_offset_out == '0, "offset on error")
   `FBPA_ASSERT_IMP(a_free_bound, clock, reset, rsp_valid, rsp_free_left <= CNT_W'(MAX_BLOCKS), "free count too large")
   // results come only out of work in progress
   `FBPA_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(busy), "result while idle")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
